### rtl/rrip_pkg.sv
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared constants, types and helpers for the dead-block aware RRIP
// replacement policy.
// ----------------------------------------------------------------------------
`default_nettype none

package rrip_pkg;

  localparam int NUM_SETS  = 2048;
  localparam int NUM_WAYS  = 16;
  localparam int SIG_BITS  = 5;
  localparam int SEL_BITS  = 10;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIG_BITS;
  localparam int SEL_HALF  = 1 << (SEL_BITS - 1);
  localparam int SEL_MAX   = (1 << SEL_BITS) - 1;

  localparam int LEADER_W  = 11;
  localparam int SHIFT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIMODAL_SHIFT = 2'd1;

  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] RRPV_NEAR  = 2'd0;
  localparam logic [1:0] RRPV_LONG  = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // one set row: re-reference values and signatures of every way
  typedef struct packed {
    logic [NUM_WAYS-1:0][1:0]          rrpv;
    logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig;
  } row_t;

  // write request to the reuse counter table
  typedef struct packed {
    logic                we;
    logic [SIG_BITS-1:0] addr;
    logic [1:0]          data;
  } cnt_wr_t;

  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.rrpv[w] = RRPV_LONG;
      r.sig[w]  = '0;
    end
    return r;
  endfunction

  function automatic logic [SIG_BITS-1:0] pc_sig(input logic [63:0] pc);
    logic [63:0] h;
    h = pc ^ (pc >> 7) ^ (pc >> 13);
    return h[SIG_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/rrip_line_store.sv
// ----------------------------------------------------------------------------
// rrip_line_store
// Per-set row memory (re-reference values and signatures) and the dead flag
// memory; one read port and one write port each, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_line_store
  import rrip_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rd_en_i,
  input  wire logic [SET_W-1:0]    rd_addr_i,
  output      row_t                rd_row_o,
  output      logic [NUM_WAYS-1:0] rd_dead_o,
  input  wire logic [SET_W-1:0]    wr_addr_i,
  input  wire logic                row_we_i,
  input  wire row_t                row_wdata_i,
  input  wire logic                dead_we_i,
  input  wire logic [NUM_WAYS-1:0] dead_wdata_i
);

  row_t                row_mem  [NUM_SETS];
  logic [NUM_WAYS-1:0] dead_mem [NUM_SETS];

  // write rows and dead flags
  always_ff @(posedge clk_i) begin
    if (row_we_i) begin
      row_mem[wr_addr_i] <= row_wdata_i;
    end
    if (dead_we_i) begin
      dead_mem[wr_addr_i] <= dead_wdata_i;
    end
  end

  // register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_o  <= row_mem[rd_addr_i];
      rd_dead_o <= dead_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/rrip_reuse_table.sv
// ----------------------------------------------------------------------------
// rrip_reuse_table
// Signature reuse counters: two registered read ports, one write port, and
// valid bits so that an unwritten counter reads as its reset value of one.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_reuse_table
  import rrip_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd0_en_i,
  input  wire logic [SIG_BITS-1:0] rd0_addr_i,
  output      logic [1:0]          rd0_data_o,
  input  wire logic                rd1_en_i,
  input  wire logic [SIG_BITS-1:0] rd1_addr_i,
  output      logic [1:0]          rd1_data_o,
  input  wire cnt_wr_t             wr_i
);

  logic [1:0]           cnt_mem [SIG_COUNT];
  logic [SIG_COUNT-1:0] vld_q;

  // write counters
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      cnt_mem[wr_i.addr] <= wr_i.data;
    end
  end

  // mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.we) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // register read data, unwritten entries read as one
  always_ff @(posedge clk_i) begin
    if (rd0_en_i) begin
      rd0_data_o <= vld_q[rd0_addr_i] ? cnt_mem[rd0_addr_i] : 2'd1;
    end
    if (rd1_en_i) begin
      rd1_data_o <= vld_q[rd1_addr_i] ? cnt_mem[rd1_addr_i] : 2'd1;
    end
  end

endmodule

`default_nettype wire

### rtl/rrip_ship_dead_block_replacement.sv
// ----------------------------------------------------------------------------
// rrip_ship_dead_block_replacement
// Last-level cache replacement policy: RRIP with signature reuse counters,
// dead flags and set dueling between two insertion policies.
//
//  channel  | direction | signals
//  ---------+-----------+---------------------------------------------------
//  in       | to block  | in_valid_i, in_ready_o, op_i, set_index_i, way_i, pc_i
//  out      | from block| out_valid_o, out_ready_i, victim_way_o, victim_was_dead_o
//  cfg      | to block  | cfg_we_i, cfg_index_i, cfg_wdata_i
//
// Victim search, hit and fill each pass through a row read, a row
// modify/write with the old-signature counter read, and a counter write-back.
// Clearing all dead flags sweeps the whole dead flag memory.
// After reset a pass over all NUM_SETS sets initialises the row memories; no
// transfer is accepted meanwhile. A full output register holds the last
// stage until its result is taken; no new item is accepted while it is held.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_ship_dead_block_replacement
  import rrip_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [10:0]          set_index_i,
  input  wire logic [3:0]           way_i,
  input  wire logic [63:0]          pc_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [3:0]           victim_way_o,
  output      logic                 victim_was_dead_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_UPD,
    S_CLR
  } state_e;

  state_e              state_q;
  logic [SET_W-1:0]    sweep_q;
  logic [LEADER_W-1:0] leader_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [SEL_BITS-1:0] sel_q, sel_d;
  logic [15:0]         lfsr_q, lfsr_d;

  // request registers
  logic [1:0]          op_q;
  logic [SET_W-1:0]    set_q;
  logic [WAY_W-1:0]    way_q;
  logic [SIG_BITS-1:0] sig_q;
  logic                way_ok_q, lead_a_q, lead_b_q;

  // result and counter write registers
  logic [3:0]          res_way_q, res_way_d;
  logic                res_dead_q, res_dead_d;
  logic [1:0]          hit_cnt_q;
  logic [SIG_BITS-1:0] old_sig;

  logic                out_valid_q;
  logic [3:0]          out_way_q;
  logic                out_dead_q;

  logic                accept;
  logic [SET_W-1:0]    set_in;
  logic [LEADER_W:0]   lead_sum;

  row_t                rd_row, wr_row;
  logic [NUM_WAYS-1:0] rd_dead, wr_dead;
  logic                row_we, dead_we;
  logic [SET_W-1:0]    wr_addr;
  logic [1:0]          cnt0, cnt1;
  cnt_wr_t             cnt_wr;
  logic                out_free;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign set_in     = SET_W'(set_index_i % NUM_SETS);
  assign lead_sum   = (LEADER_W+1)'(set_in) + (LEADER_W+1)'(leader_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign old_sig    = rd_row.sig[way_q];

  rrip_line_store u_line_store (
    .clk_i        (clk_i),
    .rd_en_i      (accept),
    .rd_addr_i    (set_in),
    .rd_row_o     (rd_row),
    .rd_dead_o    (rd_dead),
    .wr_addr_i    (wr_addr),
    .row_we_i     (row_we),
    .row_wdata_i  (wr_row),
    .dead_we_i    (dead_we),
    .dead_wdata_i (wr_dead)
  );

  rrip_reuse_table u_reuse_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd0_en_i   (accept),
    .rd0_addr_i (pc_sig(pc_i)),
    .rd0_data_o (cnt0),
    .rd1_en_i   (state_q == S_RD),
    .rd1_addr_i (old_sig),
    .rd1_data_o (cnt1),
    .wr_i       (cnt_wr)
  );

  // modify the row: search, promote, insert, sweep
  always_comb begin
    logic [1:0]  maxv;
    logic [1:0]  ins;
    logic        rare, fb, use_a, found;
    logic [15:0] lfsr_nx, mask;
    logic [SEL_BITS-1:0] s1;
    row_t        aged;

    wr_row     = rd_row;
    wr_dead    = rd_dead;
    row_we     = 1'b0;
    dead_we    = 1'b0;
    wr_addr    = set_q;
    res_way_d  = res_way_q;
    res_dead_d = res_dead_q;
    sel_d      = sel_q;
    lfsr_d     = lfsr_q;
    aged       = rd_row;
    found      = 1'b0;
    fb         = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
    lfsr_nx    = {fb, lfsr_q[15:1]};
    mask       = (16'd1 << shift_q) - 16'd1;
    rare       = ((lfsr_nx & mask) == 16'd0);
    use_a      = lead_a_q || (!lead_b_q && sel_q[SEL_BITS-1]);
    maxv       = RRPV_NEAR;
    ins        = RRPV_DISTANT;
    s1         = sel_q;

    unique case (state_q)
      S_INIT: begin
        wr_row  = reset_row();
        wr_dead = '0;
        row_we  = 1'b1;
        dead_we = 1'b1;
        wr_addr = sweep_q;
      end
      S_CLR: begin
        wr_dead = '0;
        dead_we = 1'b1;
        wr_addr = sweep_q;
      end
      S_RD: begin
        res_way_d  = '0;
        res_dead_d = 1'b0;
        unique case (op_q)
          OP_VICTIM: begin
            if (|rd_dead) begin
              // take the lowest dead way
              res_dead_d = 1'b1;
              for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (rd_dead[w]) res_way_d = 4'(w);
              end
            end else begin
              // age the set until a way reaches distant
              for (int w = 0; w < NUM_WAYS; w++) begin
                if (rd_row.rrpv[w] == 2'd3) maxv = 2'd3;
              end
              if (maxv != 2'd3) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                  if (rd_row.rrpv[w] == 2'd2) maxv = 2'd2;
                end
              end
              if (maxv == RRPV_NEAR) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                  if (rd_row.rrpv[w] == 2'd1) maxv = 2'd1;
                end
              end
              for (int w = 0; w < NUM_WAYS; w++) begin
                aged.rrpv[w] = rd_row.rrpv[w] + (RRPV_DISTANT - maxv);
              end
              for (int w = NUM_WAYS - 1; w >= 0; w--) begin
                if (aged.rrpv[w] == RRPV_DISTANT) begin
                  res_way_d = 4'(w);
                  found     = 1'b1;
                end
              end
              if (!found) res_way_d = '0;
              wr_row = aged;
              row_we = 1'b1;
            end
          end
          OP_HIT: begin
            if (way_ok_q) begin
              wr_row.rrpv[way_q] = RRPV_NEAR;
              wr_dead[way_q]     = 1'b0;
              row_we  = 1'b1;
              dead_we = 1'b1;
              if (lead_a_q && (s1 != SEL_BITS'(SEL_MAX))) s1 = s1 + 1'b1;
              if (lead_b_q && (s1 != '0)) s1 = s1 - 1'b1;
              sel_d = s1;
            end
          end
          OP_FILL: begin
            if (way_ok_q) begin
              if (rd_dead[way_q]) begin
                ins = RRPV_DISTANT;
              end else if (cnt0 >= 2'd2) begin
                ins = RRPV_NEAR;
              end else begin
                lfsr_d = lfsr_nx;
                if (use_a) ins = rare ? RRPV_LONG : RRPV_DISTANT;
                else       ins = rare ? RRPV_NEAR : RRPV_LONG;
              end
              wr_row.rrpv[way_q] = ins;
              wr_row.sig[way_q]  = sig_q;
              wr_dead[way_q]     = 1'b1;
              row_we  = 1'b1;
              dead_we = 1'b1;
            end
          end
          OP_CLEAR: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // counter write-back in the last stage
  always_comb begin
    cnt_wr = '0;
    if (state_q == S_UPD && way_ok_q) begin
      if (op_q == OP_HIT) begin
        cnt_wr.we   = 1'b1;
        cnt_wr.addr = sig_q;
        cnt_wr.data = hit_cnt_q;
      end else if (op_q == OP_FILL) begin
        cnt_wr.we   = 1'b1;
        cnt_wr.addr = old_sig;
        cnt_wr.data = (cnt1 != 2'd0) ? cnt1 - 2'd1 : 2'd0;
      end
    end
  end

  // sequence the operation, hold state, configuration and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      leader_q    <= LEADER_W'(32);
      shift_q     <= SHIFT_W'(5);
      sel_q       <= SEL_BITS'(SEL_HALF);
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
      out_way_q   <= '0;
      out_dead_q  <= 1'b0;
    end else begin
      sel_q  <= sel_d;
      lfsr_q <= lfsr_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_LEADER_COUNT) begin
          leader_q <= cfg_wdata_i[LEADER_W-1:0];
        end else if (cfg_index_i == CFG_BIMODAL_SHIFT) begin
          shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        end
      end
      if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == SET_W'(NUM_SETS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state_q <= S_RD;
        end
        S_RD: begin
          sweep_q <= '0;
          state_q <= (op_q == OP_CLEAR) ? S_CLR : S_UPD;
        end
        S_CLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == SET_W'(NUM_SETS - 1)) state_q <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_way_q   <= res_way_q;
            out_dead_q  <= res_dead_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // capture the request and the stage results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      set_q    <= set_in;
      way_q    <= way_i[WAY_W-1:0];
      sig_q    <= pc_sig(pc_i);
      way_ok_q <= (int'(way_i) < NUM_WAYS);
      lead_a_q <= ((LEADER_W+1)'(set_in) < (LEADER_W+1)'(leader_q));
      lead_b_q <= (lead_sum >= (LEADER_W+1)'(NUM_SETS));
    end
    if (state_q == S_RD) begin
      hit_cnt_q <= (cnt0 != 2'd3) ? cnt0 + 2'd1 : 2'd3;
    end
    res_way_q  <= res_way_d;
    res_dead_q <= res_dead_d;
  end

  assign out_valid_o       = out_valid_q;
  assign victim_way_o      = out_way_q;
  assign victim_was_dead_o = out_dead_q;

  // checks on the sequencing
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("transfer accepted while an operation is in flight");

  a_cnt_wr_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_wr.we |-> (state_q == S_UPD))
    else $error("counter written outside the write-back stage");

  a_row_wr_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> (state_q == S_RD || state_q == S_INIT))
    else $error("row written outside the modify stage");

  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != 16'd0)
    else $error("random register locked at zero");

  a_dead_only_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && res_dead_q) |-> (op_q == OP_VICTIM))
    else $error("dead victim flagged for a non-search operation");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the dead-block aware RRIP replacement policy.
// A scoreboard keeps its own copy of the per-line state, the reuse counters,
// the duel selector and the random generator. It predicts the victim result
// of each accepted access and compares it with the transfer that comes out.
// The stimulus is a directed opening, then random accesses mostly over a small
// pool of sets and program counters, under several leader and bimodal settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rrip_pkg::*;

  localparam int LINE_COUNT = NUM_SETS * NUM_WAYS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SWEEP_WAIT = NUM_SETS + 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  typedef struct packed {
    logic [3:0] way;
    logic       dead;
  } victim_t;

  // Scoreboard: own copy of the policy state and the queue of expected victims
  class replacement_scoreboard;
    logic [1:0]          rrpv [LINE_COUNT];
    logic [SIG_BITS-1:0] line_sig [LINE_COUNT];
    logic                dead [LINE_COUNT];
    logic [1:0]          reuse [SIG_COUNT];
    int unsigned         selector;
    logic [15:0]         lfsr;
    int unsigned         leaders;
    int unsigned         shift;
    victim_t             victim_q [$];
    int unsigned         mismatches;

    function new();
      for (int i = 0; i < LINE_COUNT; i++) begin
        rrpv[i] = RRPV_LONG;
        line_sig[i] = '0;
        dead[i] = 1'b0;
      end
      for (int i = 0; i < SIG_COUNT; i++) reuse[i] = 2'd1;
      selector = SEL_HALF;
      lfsr = LFSR_SEED;
      leaders = 32;
      shift = 5;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_LEADER_COUNT) leaders = data;
      else if (idx == CFG_BIMODAL_SHIFT) shift = data[3:0];
    endfunction

    // step the generator and report whether the rare insertion is chosen
    function bit rare_pick();
      logic fb;
      logic [15:0] mask;
      fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
      lfsr = {fb, lfsr[15:1]};
      mask = (16'd1 << shift) - 16'd1;
      return (lfsr & mask) == 16'd0;
    endfunction

    function void note_access(logic [1:0] op, logic [10:0] set_idx, logic [3:0] way_idx,
                              logic [63:0] pc);
      victim_t res;
      int unsigned base, line, maxv;
      bit lead_a, lead_b, use_a, found;
      logic [SIG_BITS-1:0] sig, old_sig;
      logic [63:0] h;
      logic [1:0] ins;
      res = '0;
      base = set_idx * NUM_WAYS;
      line = base + way_idx;
      lead_a = set_idx < leaders;
      lead_b = (set_idx + leaders) >= NUM_SETS;
      h = pc ^ (pc >> 7) ^ (pc >> 13);
      sig = h[SIG_BITS-1:0];
      found = 0;
      maxv = 0;
      case (op)
        OP_VICTIM: begin
          for (int w = 0; w < NUM_WAYS; w++)
            if (!found && dead[base + w]) begin
              res.way = 4'(w);
              res.dead = 1'b1;
              found = 1;
            end
          if (!found) begin
            // age the set until the oldest way reaches distant
            for (int w = 0; w < NUM_WAYS; w++)
              if (rrpv[base + w] > maxv) maxv = rrpv[base + w];
            for (int w = 0; w < NUM_WAYS; w++)
              rrpv[base + w] = rrpv[base + w] + 2'(3 - maxv);
            for (int w = 0; w < NUM_WAYS; w++)
              if (!found && rrpv[base + w] == RRPV_DISTANT) begin
                res.way = 4'(w);
                found = 1;
              end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < LINE_COUNT; i++) dead[i] = 1'b0;
        end
        OP_HIT: begin
          rrpv[line] = RRPV_NEAR;
          if (reuse[sig] < 3) reuse[sig]++;
          dead[line] = 1'b0;
          if (lead_a && selector < SEL_MAX) selector++;
          if (lead_b && selector > 0) selector--;
        end
        default: begin
          old_sig = line_sig[line];
          use_a = lead_a ? 1'b1 : (lead_b ? 1'b0 : (selector >= SEL_HALF));
          if (dead[line]) ins = RRPV_DISTANT;
          else if (reuse[sig] >= 2) ins = RRPV_NEAR;
          else if (use_a) ins = rare_pick() ? RRPV_LONG : RRPV_DISTANT;
          else ins = rare_pick() ? RRPV_NEAR : RRPV_LONG;
          if (reuse[old_sig] > 0) reuse[old_sig]--;
          line_sig[line] = sig;
          rrpv[line] = ins;
          dead[line] = 1'b1;
        end
      endcase
      victim_q.push_back(res);
    endfunction

    function void check_victim(logic [3:0] way_o, logic dead_o);
      victim_t want;
      if (victim_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: way %0d dead %0d", way_o, dead_o);
        return;
      end
      want = victim_q.pop_front();
      if (want.way !== way_o || want.dead !== dead_o) begin
        mismatches++;
        if (mismatches <= 10)
          $display("victim mismatch: expected way %0d dead %0d, got way %0d dead %0d",
                   want.way, want.dead, way_o, dead_o);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           op_i = OP_VICTIM;
  logic [10:0]          set_index_i = '0;
  logic [3:0]           way_i = '0;
  logic [63:0]          pc_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [3:0]           victim_way_o;
  logic                 victim_was_dead_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  replacement_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned rx_mode = 0, rx_phase = 0, rx_hold = 0;
  logic [63:0] pc_pool [8];
  logic [10:0] set_pool [12];

  rrip_ship_dead_block_replacement i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Note accepted accesses and check outgoing transfers
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_access(op_i, set_index_i, way_i, pc_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_victim(victim_way_o, victim_was_dead_o);
  end

  // Receiver stalls, with a pattern picked anew whenever its phase counter runs out
  always @(negedge clk_i) begin
    if (rx_phase == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_phase = $urandom_range(50, 300);
    end else begin
      rx_phase--;
    end
    if (rx_hold > 0) begin
      out_ready_i = 1'b0;
      rx_hold--;
    end else begin
      out_ready_i = 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 2);
      else if (rx_mode == 2 && $urandom_range(0, 1) == 0) rx_hold = $urandom_range(1, 8);
    end
  end

  // Present one access and hold it until the transfer
  task automatic send(logic [1:0] op, logic [10:0] set_idx, logic [3:0] way_idx,
                      logic [63:0] pc);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i = op;
    set_index_i = set_idx;
    way_i = way_idx;
    pc_i = pc;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause(int unsigned n);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.victim_q.size() != 0) @(posedge clk_i);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    drain();
    repeat (SWEEP_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned burst, pick;
    logic [1:0] op;
    logic [10:0] set_idx;
    logic [63:0] pc;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
      burst--;
      if (i == count / 2) drain();
      pick = $urandom_range(0, 99);
      op = pick < 30 ? OP_VICTIM : pick < 60 ? OP_HIT : pick < 98 ? OP_FILL : OP_CLEAR;
      set_idx = $urandom_range(0, 3) == 0 ? 11'($urandom) : set_pool[$urandom_range(0, 11)];
      pc = $urandom_range(0, 4) == 0 ? {$urandom, $urandom} : pc_pool[$urandom_range(0, 7)];
      send(op, set_idx, 4'($urandom), pc);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) pc_pool[i] = {$urandom, $urandom};
    set_pool = '{11'd0, 11'd1, 11'd31, 11'd32, 11'd33, 11'd1023, 11'd1024,
                 11'd2014, 11'd2015, 11'd2016, 11'd2046, 11'd2047};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening
    send(OP_VICTIM, 11'd0, 4'd0, 64'd0);
    send(OP_FILL, 11'd0, 4'd0, 64'd0);
    send(OP_VICTIM, 11'd0, 4'd9, 64'd0);
    send(OP_HIT, 11'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_VICTIM, 11'd0, 4'd0, 64'd0);
    send(OP_FILL, 11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_FILL, 11'd2047, 4'd15, 64'h5555_AAAA_5555_AAAA);
    send(OP_VICTIM, 11'd2047, 4'd0, 64'd0);
    send(OP_HIT, 11'd2047, 4'd15, 64'hAAAA_5555_AAAA_5555);
    send(OP_HIT, 11'd2047, 4'd15, 64'hAAAA_5555_AAAA_5555);
    send(OP_FILL, 11'd1000, 4'd3, 64'h0000_0000_0000_0080);
    send(OP_FILL, 11'd1000, 4'd4, 64'hAAAA_5555_AAAA_5555);
    send(OP_CLEAR, 11'd0, 4'd0, 64'd0);
    send(OP_VICTIM, 11'd2047, 4'd0, 64'd0);
    send(OP_VICTIM, 11'd1000, 4'd0, 64'd0);
    send(OP_VICTIM, 11'd5, 4'd0, 64'd0);

    // Random phases under several register settings
    random_phase(60);
    write_cfg(CFG_LEADER_COUNT, 11'd0);
    write_cfg(CFG_BIMODAL_SHIFT, 11'd0);
    random_phase(80);
    write_cfg(CFG_LEADER_COUNT, 11'd2047);
    write_cfg(CFG_BIMODAL_SHIFT, 11'd15);
    write_cfg(CFG_SPARE, 11'd7);
    random_phase(80);
    write_cfg(CFG_LEADER_COUNT, 11'd1);
    write_cfg(CFG_BIMODAL_SHIFT, 11'd1);
    random_phase(80);
    write_cfg(CFG_LEADER_COUNT, 11'd1024);
    write_cfg(CFG_BIMODAL_SHIFT, 11'd3);
    random_phase(80);

    // Wait for the last transfers, then settle
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.victim_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### rrip_ship_dead_block_replacement.f
rtl/rrip_pkg.sv
rtl/rrip_line_store.sv
rtl/rrip_reuse_table.sv
rtl/rrip_ship_dead_block_replacement.sv
tb/sv/tb_top.sv
